### src/adcpp_pkg.sv
// shared types, constants and lookup tables for the adc sensor postprocessor
package adcpp_pkg;

  // default slot count, handed to the top level parameter
  localparam int NUM_SLOTS_DEF  = 4;

  // fixed-point format and field widths
  localparam int FRAC_BITS      = 16;
  localparam int Q_W            = FRAC_BITS + 2;
  localparam int RAW_W          = 12;
  localparam int CFG_W          = 12;
  localparam int CPU_W          = 16;
  localparam int EXT_W          = 11;
  localparam int OUT_SLOT_W     = 2;

  // filter and conversion constants
  localparam int FILTER_DIVISOR = 20;
  localparam int ADC_FULL       = 4095;
  localparam int CPU_TENTHS_K   = 1000;
  localparam int CPU_OFFSET_K   = 300;
  localparam longint unsigned Q_ONE = 64'd1 << FRAC_BITS;
  localparam int ZERO_THRESH    = int'((Q_ONE + 64'd9999) / 64'd10000);
  localparam logic [Q_W-1:0] Q_MAX = '1;

  // thermistor table
  localparam int TABLE_POINTS   = 10;
  localparam int TIDX_W         = 5;
  localparam int TEMP_BASE      = 100;
  localparam int TEMP_STEP      = 128;
  localparam int TEMP_SHIFT     = $clog2(TEMP_STEP);
  localparam int TEMP_BELOW     = TEMP_BASE + TEMP_STEP * (TABLE_POINTS - 1) + 1;

  // shared divider sizing
  localparam int DIV_W          = 41;
  localparam int ACC_W          = DIV_W + 1;
  localparam int DSR_W          = CFG_W + FRAC_BITS;
  localparam int DCNT_W         = 6;
  localparam int NORM_LEN       = RAW_W + Q_W;
  localparam int DIFF_LEN       = Q_W + 1;
  localparam int RATIO_LEN      = CFG_W + FRAC_BITS;
  localparam int TH_LEN         = Q_W + TEMP_SHIFT;

  // reciprocals for the fixed divisors, exact over the full operand range
  localparam int NREC_K = NORM_LEN + $clog2(ADC_FULL);
  localparam longint unsigned NREC_M =
    ((64'd1 << NREC_K) + 64'(ADC_FULL) - 64'd1) / 64'(ADC_FULL);
  localparam int NREC_W = $clog2(NREC_M + 64'd1);
  localparam int FREC_K = DIFF_LEN + $clog2(FILTER_DIVISOR);
  localparam longint unsigned FREC_M =
    ((64'd1 << FREC_K) + 64'(FILTER_DIVISOR) - 64'd1) / 64'(FILTER_DIVISOR);
  localparam int FREC_W = $clog2(FREC_M + 64'd1);

  // table level in units of 1e-4, rounded to the q format
  function automatic logic [Q_W-1:0] lvl(input longint unsigned tenk);
    longint unsigned v;
    v = (tenk * Q_ONE + 64'd5000) / 64'd10000;
    return v[Q_W-1:0];
  endfunction

  localparam logic [Q_W-1:0] LEVEL_Q [16] = '{
    lvl(8634), lvl(7757), lvl(6654), lvl(5444), lvl(4274), lvl(3257),
    lvl(2437), lvl(1810), lvl(1346), lvl(1006), lvl(0), lvl(0),
    lvl(0), lvl(0), lvl(0), lvl(0)
  };

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_VREF_CAL      = 2'd0,
    REG_TEMP_CAL_LOW  = 2'd1,
    REG_TEMP_CAL_HIGH = 2'd2
  } cfg_reg_e;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_NORM,
    OP_STEP,
    OP_UPDATE,
    OP_RATIO_DIV,
    OP_RATIO_WR,
    OP_CT_MUL1,
    OP_CT_MUL2,
    OP_CT_DIV,
    OP_CT_WR,
    OP_TH_NEXT,
    OP_TH_TOP,
    OP_TH_LOW,
    OP_TH_DIV,
    OP_TH_WR,
    OP_FINISH
  } op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_STEP,
    ST_UPDATE,
    ST_BRANCH,
    ST_RDIV_WAIT,
    ST_CT2,
    ST_CT3,
    ST_CDIV_WAIT,
    ST_TH_SRCH,
    ST_TDIV_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic raw_zero;
    logic cal_equal;
    logic is_ref;
    logic is_cpu;
    logic is_th;
    logic th_top;
    logic th_below;
    logic th_hit;
  } status_t;

endpackage

### src/adc_sensor_postprocessor.sv
// top level of the adc sensor postprocessor
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ------------------------------------
// sample    in         in_valid_i / in_ready_o     raw_sample_i
// result    out        out_valid_o / out_ready_i   channel_done_o, filtered_level_o,
//                                                  cpu_temp_tenths_o, ext_temp_o,
//                                                  next_channel_o
// config    in         cfg_we_i                    cfg_index_i, cfg_data_i
//
// the reference, cpu and thermistor slots use the shared bit-serial divider, one quotient
// bit per cycle over 25 to 41 bits; the core supply slot uses no division. scaling and
// the filter step use reciprocal multiplies. the table search on the thermistor slot
// steps through one table point at a time.
// the result register lets a new sample be taken while a result waits, but the
// next result is held back until the waiting one is taken.
// reset clears the slot pointer, filter state, ratio and held temperatures at once.
module adc_sensor_postprocessor
  import adcpp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RAW_W-1:0]        raw_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OUT_SLOT_W-1:0]   channel_done_o,
  output logic [Q_W-1:0]          filtered_level_o,
  output logic signed [CPU_W-1:0] cpu_temp_tenths_o,
  output logic [EXT_W-1:0]        ext_temp_o,
  output logic [OUT_SLOT_W-1:0]   next_channel_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  adcpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  adcpp_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .raw_sample_i      (raw_sample_i),
    .channel_done_o    (channel_done_o),
    .filtered_level_o  (filtered_level_o),
    .cpu_temp_tenths_o (cpu_temp_tenths_o),
    .ext_temp_o        (ext_temp_o),
    .next_channel_o    (next_channel_o)
  );

endmodule

### src/adcpp_divider.sv
// shared restoring divider, one quotient bit per cycle
module adcpp_divider
  import adcpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DSR_W-1:0]  divisor_i,
  input  logic [DCNT_W-1:0] len_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DIV_W-1:0]  quotient_o
);

  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DSR_W-1:0]  dsr_q, dsr_d;
  logic [DSR_W-1:0]  rem_q, rem_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] bit_idx;
  logic [DSR_W:0]    trial;

  // one shift-subtract step
  always_comb begin
    bit_idx = cnt_q - DCNT_W'(1);
    trial   = {rem_q, dvd_q[bit_idx]};
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      quo_d  = '0;
      rem_d  = '0;
      cnt_d  = len_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DSR_W'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DSR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // a new division never starts over a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

### src/adcpp_datapath.sv
// datapath: sample scaling, per-slot filter, ratio, cpu and thermistor conversion
module adcpp_datapath
  import adcpp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic [RAW_W-1:0]       raw_sample_i,
  output logic [OUT_SLOT_W-1:0]  channel_done_o,
  output logic [Q_W-1:0]         filtered_level_o,
  output logic signed [CPU_W-1:0] cpu_temp_tenths_o,
  output logic [EXT_W-1:0]       ext_temp_o,
  output logic [OUT_SLOT_W-1:0]  next_channel_o
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int T2_W   = Q_W + RAW_W + 1;
  localparam int NP_W   = NORM_LEN + NREC_W;
  localparam int NQ_W   = NP_W - NREC_K;
  localparam int SP_W   = DIFF_LEN + FREC_W;

  // configuration registers
  logic [CFG_W-1:0] vref_q, cal_lo_q, cal_hi_q;

  // item state
  logic [RAW_W-1:0]  raw_q;
  logic [Q_W-1:0]    ratio_q;
  logic [Q_W-1:0]    store_q [NUM_SLOTS];
  logic [SLOT_W-1:0] slot_q, slot_next;
  logic [Q_W-1:0]    fv_q;
  logic [Q_W-1:0]    norm_q;
  logic [Q_W:0]      step_q;
  logic              neg_q;
  logic signed [ACC_W-1:0] acc_q, acc2_q;
  logic [TIDX_W-1:0] idx_q;
  logic signed [CPU_W-1:0] cpu_q;
  logic [EXT_W-1:0]  ext_q;

  // result registers
  logic [OUT_SLOT_W-1:0]   chan_out_q, next_out_q;
  logic [Q_W-1:0]          lvl_out_q;
  logic signed [CPU_W-1:0] cpu_out_q;
  logic [EXT_W-1:0]        ext_out_q;

  // divider hookup
  logic              div_start, div_busy, div_done;
  logic [DIV_W-1:0]  div_dividend, div_quo;
  logic [DSR_W-1:0]  div_divisor;
  logic [DCNT_W-1:0] div_len;

  // combinational helpers
  logic [Q_W-1:0]    old_v, quo_sat, nv;
  logic [NP_W-1:0]   norm_prod;
  logic [NQ_W-1:0]   norm_quo;
  logic [Q_W-1:0]    norm_sat;
  logic [SP_W-1:0]   step_prod;
  logic [Q_W:0]      step_mag;
  logic signed [Q_W:0] diff;
  logic [Q_W:0]      diff_mag;
  logic signed [Q_W+1:0] nv_s;
  logic signed [CFG_W:0] dcal;
  logic [CFG_W-1:0]  dcal_mag;
  logic [DSR_W-1:0]  den_mag;
  logic signed [CFG_W+10:0] dc300;
  logic [Q_W+RAW_W-1:0] prod_raw, prod_fv;
  logic signed [T2_W-1:0] t2;
  logic signed [ACC_W-1:0] m2, num;
  logic [DIV_W-1:0]  num_mag;
  logic [CPU_W-1:0]  cpu_sat;
  logic [Q_W-1:0]    lvl_cur, lvl_prev, th_d, span;
  logic [EXT_W:0]    th_base;
  logic signed [DIV_W:0] th_r;

  adcpp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .len_i      (div_len),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // scaling, filter step and clamp
  always_comb begin
    old_v     = store_q[slot_q];
    quo_sat   = (|div_quo[DIV_W-1:Q_W]) ? Q_MAX : div_quo[Q_W-1:0];
    // divide by full scale through the reciprocal
    norm_prod = acc_q[NORM_LEN-1:0] * NREC_W'(NREC_M);
    norm_quo  = norm_prod[NP_W-1:NREC_K];
    norm_sat  = (|norm_quo[NQ_W-1:Q_W]) ? Q_MAX : norm_quo[Q_W-1:0];
    diff      = $signed({1'b0, norm_q}) - $signed({1'b0, old_v});
    diff_mag  = diff[Q_W] ? (Q_W+1)'(-diff) : (Q_W+1)'(diff);
    // step magnitude, truncated toward zero
    step_prod = diff_mag * FREC_W'(FREC_M);
    step_mag  = (Q_W+1)'(step_prod[SP_W-1:FREC_K]);
    nv_s      = neg_q ? $signed({2'b0, old_v}) - $signed({1'b0, step_q})
                      : $signed({2'b0, old_v}) + $signed({1'b0, step_q});
    if (nv_s[Q_W+1]) begin
      nv = '0;
    end else if (nv_s[Q_W]) begin
      nv = Q_MAX;
    end else if (nv_s[Q_W-1:0] < Q_W'(ZERO_THRESH)) begin
      nv = '0;
    end else begin
      nv = nv_s[Q_W-1:0];
    end
    prod_raw = raw_q * ratio_q;
    prod_fv  = fv_q * RAW_W'(ADC_FULL);
  end

  // cpu temperature terms
  always_comb begin
    dcal     = $signed({1'b0, cal_hi_q}) - $signed({1'b0, cal_lo_q});
    dcal_mag = dcal[CFG_W] ? CFG_W'(-dcal) : dcal[CFG_W-1:0];
    den_mag  = {dcal_mag, {FRAC_BITS{1'b0}}};
    dc300    = dcal * $signed(11'(CPU_OFFSET_K));
    t2       = $signed({1'b0, acc_q[Q_W+RAW_W-1:0]})
             - $signed({{(T2_W-DSR_W){1'b0}}, cal_lo_q, {FRAC_BITS{1'b0}}});
    m2       = t2 * $signed(11'(CPU_TENTHS_K));
    num      = acc_q + acc2_q;
    num_mag  = num[ACC_W-1] ? DIV_W'(-num) : num[DIV_W-1:0];
    if (neg_q) begin
      cpu_sat = (div_quo > DIV_W'(32768)) ? {1'b1, {(CPU_W-1){1'b0}}}
                                          : CPU_W'(-div_quo[CPU_W-1:0]);
    end else begin
      cpu_sat = (div_quo > DIV_W'(32767)) ? {1'b0, {(CPU_W-1){1'b1}}}
                                          : div_quo[CPU_W-1:0];
    end
  end

  // thermistor table lookup
  always_comb begin
    lvl_cur  = LEVEL_Q[idx_q[3:0]];
    lvl_prev = LEVEL_Q[idx_q[3:0] - 4'd1];
    th_d     = (lvl_prev > lvl_cur) ? lvl_prev - lvl_cur : Q_W'(1);
    span     = fv_q - lvl_cur;
    th_base  = (EXT_W+1)'(TEMP_BASE) + (EXT_W+1)'({idx_q, {TEMP_SHIFT{1'b0}}});
    th_r     = $signed({1'b0, DIV_W'(th_base)}) - $signed({1'b0, div_quo});
  end

  // divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_len      = '0;
    case (cmd_i.op)
      OP_RATIO_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({vref_q, {FRAC_BITS{1'b0}}});
        div_divisor  = DSR_W'(raw_q);
        div_len      = DCNT_W'(RATIO_LEN);
      end
      OP_CT_DIV: begin
        div_start    = 1'b1;
        div_dividend = num_mag;
        div_divisor  = den_mag;
        div_len      = DCNT_W'(DIV_W);
      end
      OP_TH_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({span, {TEMP_SHIFT{1'b0}}});
        div_divisor  = DSR_W'(th_d);
        div_len      = DCNT_W'(TH_LEN);
      end
      default: ;
    endcase
  end

  assign slot_next = (slot_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot_q + SLOT_W'(1);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q   <= CFG_W'(1660);
      cal_lo_q <= CFG_W'(1000);
      cal_hi_q <= CFG_W'(1350);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VREF_CAL:      vref_q   <= cfg_data_i;
        REG_TEMP_CAL_LOW:  cal_lo_q <= cfg_data_i;
        REG_TEMP_CAL_HIGH: cal_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state that persists across transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      ratio_q <= '0;
      cpu_q   <= '0;
      ext_q   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      case (cmd_i.op)
        OP_UPDATE:   store_q[slot_q] <= nv;
        OP_RATIO_WR: ratio_q <= quo_sat;
        OP_CT_WR:    cpu_q <= $signed(cpu_sat);
        OP_TH_TOP:   ext_q <= EXT_W'(TEMP_BASE);
        OP_TH_LOW:   ext_q <= EXT_W'(TEMP_BELOW);
        OP_TH_WR:    ext_q <= th_r[DIV_W] ? '0 : th_r[EXT_W-1:0];
        OP_FINISH:   slot_q <= slot_next;
        default: ;
      endcase
    end
  end

  // working registers of one transaction
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        raw_q <= raw_sample_i;
        idx_q <= '0;
      end
      OP_MUL:      acc_q  <= ACC_W'(prod_raw);
      OP_NORM:     norm_q <= norm_sat;
      OP_STEP: begin
        neg_q  <= diff[Q_W];
        step_q <= step_mag;
      end
      OP_UPDATE:   fv_q  <= nv;
      OP_CT_MUL1: begin
        acc_q  <= ACC_W'(prod_fv);
        acc2_q <= ACC_W'($signed({dc300, {FRAC_BITS{1'b0}}}));
      end
      OP_CT_MUL2:  acc_q <= m2;
      OP_CT_DIV:   neg_q <= num[ACC_W-1] ^ dcal[CFG_W];
      OP_TH_NEXT:  idx_q <= idx_q + TIDX_W'(1);
      OP_FINISH: begin
        chan_out_q <= OUT_SLOT_W'(slot_q);
        lvl_out_q  <= fv_q;
        cpu_out_q  <= cpu_q;
        ext_out_q  <= ext_q;
        next_out_q <= OUT_SLOT_W'(slot_next);
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    status_o.div_done  = div_done;
    status_o.raw_zero  = (raw_q == '0);
    status_o.cal_equal = (cal_hi_q == cal_lo_q);
    status_o.is_ref    = (slot_q == SLOT_W'(0));
    status_o.is_cpu    = (slot_q == SLOT_W'(1));
    status_o.is_th     = (slot_q == SLOT_W'(2));
    status_o.th_below  = (idx_q >= TIDX_W'(TABLE_POINTS));
    status_o.th_top    = (idx_q == '0) && (fv_q >= LEVEL_Q[0]);
    status_o.th_hit    = (idx_q != '0) && !status_o.th_below && (fv_q >= lvl_cur);
  end

  assign channel_done_o    = chan_out_q;
  assign filtered_level_o  = lvl_out_q;
  assign cpu_temp_tenths_o = cpu_out_q;
  assign ext_temp_o        = ext_out_q;
  assign next_channel_o    = next_out_q;

  // done only follows a running division
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> $past(div_busy))
    else $error("divider done without a running division");

endmodule

### src/adcpp_ctrl.sv
// controller: sequences one transaction through the datapath operations
module adcpp_ctrl
  import adcpp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_stall;

  assign out_stall = out_valid_q && !out_ready_i;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_NORM;
      end
      ST_NORM: begin
        cmd_o.op = OP_NORM;
        state_d  = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.op = OP_STEP;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (status_i.is_ref) begin
          if (!status_i.raw_zero) begin
            cmd_o.op = OP_RATIO_DIV;
            state_d  = ST_RDIV_WAIT;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (status_i.is_cpu) begin
          if (!status_i.cal_equal) begin
            cmd_o.op = OP_CT_MUL1;
            state_d  = ST_CT2;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (status_i.is_th) begin
          state_d = ST_TH_SRCH;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_RDIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_RATIO_WR;
          state_d  = ST_FINISH;
        end
      end
      ST_CT2: begin
        cmd_o.op = OP_CT_MUL2;
        state_d  = ST_CT3;
      end
      ST_CT3: begin
        cmd_o.op = OP_CT_DIV;
        state_d  = ST_CDIV_WAIT;
      end
      ST_CDIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_CT_WR;
          state_d  = ST_FINISH;
        end
      end
      ST_TH_SRCH: begin
        if (status_i.th_top) begin
          cmd_o.op = OP_TH_TOP;
          state_d  = ST_FINISH;
        end else if (status_i.th_below) begin
          cmd_o.op = OP_TH_LOW;
          state_d  = ST_FINISH;
        end else if (status_i.th_hit) begin
          cmd_o.op = OP_TH_DIV;
          state_d  = ST_TDIV_WAIT;
        end else begin
          cmd_o.op = OP_TH_NEXT;
        end
      end
      ST_TDIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_TH_WR;
          state_d  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_stall) begin
          cmd_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // result register is never overwritten while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_FINISH) |-> !out_stall)
    else $error("result overwritten while stalled");

  // an accepted sample always starts the scaling multiply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MUL))
    else $error("accepted sample did not start processing");

  // divider completion only lands in a waiting state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_RDIV_WAIT || state_q == ST_CDIV_WAIT ||
                           state_q == ST_TDIV_WAIT))
    else $error("division finished outside a wait state");

endmodule

### sim/testbench.sv
// self-checking testbench for the adc sensor postprocessor
`timescale 1ns / 1ps

module testbench;
  import adcpp_pkg::*;

  typedef struct {
    logic [OUT_SLOT_W-1:0]   slot;
    logic [Q_W-1:0]          level;
    logic signed [CPU_W-1:0] cpu;
    logic [EXT_W-1:0]        ext;
    logic [OUT_SLOT_W-1:0]   nxt;
  } result_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [RAW_W-1:0]        raw_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [OUT_SLOT_W-1:0]   channel_done_o;
  logic [Q_W-1:0]          filtered_level_o;
  logic signed [CPU_W-1:0] cpu_temp_tenths_o;
  logic [EXT_W-1:0]        ext_temp_o;
  logic [OUT_SLOT_W-1:0]   next_channel_o;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_data_i = '0;

  // sender and receiver queues
  logic [RAW_W-1:0] sample_q[$];
  result_t          expected_q[$];
  int               err_cnt = 0;
  bit               idle_en = 1'b1;
  int               in_gap = 0;
  int               out_gap = 0;
  int               quiet_cnt = 0;

  // predictor state and configuration copy
  longint unsigned vref_m, cal_lo_m, cal_hi_m;
  int unsigned     slot_m;
  longint unsigned filt_m[NUM_SLOTS_DEF];
  longint unsigned ratio_m;
  logic signed [CPU_W-1:0] cpu_m;
  logic [EXT_W-1:0]        ext_m;

  always #6 clk_i = ~clk_i;

  adc_sensor_postprocessor u_dut (.*);

  // thermistor table level rounded to q format
  function automatic longint unsigned therm_level(int unsigned i);
    longint unsigned tenk[10] = '{8634, 7757, 6654, 5444, 4274, 3257, 2437, 1810, 1346, 1006};
    longint unsigned t;
    t = (i < 10) ? tenk[i] : 0;
    return (t * 65536 + 5000) / 10000;
  endfunction

  function automatic logic [EXT_W-1:0] therm_temp(longint unsigned v);
    longint unsigned lo, hi, d, t;
    longint r;
    if (v >= therm_level(0)) return EXT_W'(TEMP_BASE);
    for (int i = 1; i < TABLE_POINTS; i++) begin
      lo = therm_level(i);
      if (v >= lo) begin
        hi = therm_level(i - 1);
        d = (hi > lo) ? hi - lo : 1;
        t = ((v - lo) * TEMP_STEP) / d;
        r = longint'(TEMP_BASE + TEMP_STEP * i) - longint'(t);
        return EXT_W'(r < 0 ? 0 : r);
      end
    end
    return EXT_W'(TEMP_BELOW);
  endfunction

  // compute the result of one sample and advance the model state
  task automatic predict_sample(input logic [RAW_W-1:0] raw);
    longint unsigned norm, qmax;
    longint old, stp, nv, lo, hi, den, num, q;
    int unsigned s;
    result_t r;
    qmax = (64'd1 << Q_W) - 1;
    s = slot_m;
    norm = longint'(raw) * ratio_m / ADC_FULL;
    if (norm > qmax) norm = qmax;
    old = longint'(filt_m[s]);
    stp = (longint'(norm) - old) / FILTER_DIVISOR;
    nv = old + stp;
    if (nv < 0) nv = 0;
    if (nv > longint'(qmax)) nv = longint'(qmax);
    if (nv < ZERO_THRESH) nv = 0;
    filt_m[s] = nv;
    if (s == 0) begin
      if (raw != 0) begin
        norm = (vref_m << FRAC_BITS) / raw;
        ratio_m = (norm > qmax) ? qmax : norm;
      end
    end else if (s == 1) begin
      lo = cal_lo_m;
      hi = cal_hi_m;
      if (hi != lo) begin
        den = (hi - lo) * 65536;
        num = 1000 * (nv * ADC_FULL - lo * 65536) + 300 * den;
        q = num / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        cpu_m = CPU_W'(q);
      end
    end else if (s == 2) begin
      ext_m = therm_temp(filt_m[s]);
    end
    slot_m = (s + 1 >= NUM_SLOTS_DEF) ? 0 : s + 1;
    r.slot = s[1:0];
    r.level = filt_m[s][Q_W-1:0];
    r.cpu = cpu_m;
    r.ext = ext_m;
    r.nxt = slot_m[1:0];
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_sample(raw_sample_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() > 0) begin
          raw_sample_i <= sample_q.pop_front();
          in_valid_i <= 1'b1;
          if (idle_en && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 6);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back pressure
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", channel_done_o, -1);
        end else begin
          e = expected_q.pop_front();
          if (channel_done_o !== e.slot) report_mismatch("channel_done", channel_done_o, e.slot);
          if (filtered_level_o !== e.level)
            report_mismatch("filtered_level", filtered_level_o, e.level);
          if (cpu_temp_tenths_o !== e.cpu)
            report_mismatch("cpu_temp_tenths", cpu_temp_tenths_o, e.cpu);
          if (ext_temp_o !== e.ext) report_mismatch("ext_temp", ext_temp_o, e.ext);
          if (next_channel_o !== e.nxt) report_mismatch("next_channel", next_channel_o, e.nxt);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 6);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i ||
        (sample_q.size() == 0 && !in_valid_i && expected_q.size() == 0))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_VREF_CAL:      vref_m = val;
      REG_TEMP_CAL_LOW:  cal_lo_m = val;
      default:           cal_hi_m = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every sample is taken and every result has arrived
  task automatic wait_idle();
    while (sample_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [RAW_W-1:0] jitter(int v, int amt);
    int x;
    x = v + $urandom_range(0, 2 * amt) - amt;
    if (x < 0) x = 0;
    if (x > 4095) x = 4095;
    return RAW_W'(x);
  endfunction

  // random stimulus: mostly steady per-slot levels so the filters settle, some noise
  task automatic fill_random(input int count);
    int n, reps;
    int tgt[4];
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) != 0) begin
        tgt[0] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(1200, 2200);
        for (int k = 1; k < 4; k++) tgt[k] = $urandom_range(0, 4095);
        reps = $urandom_range(5, 25);
        for (int r = 0; r < reps; r++)
          for (int k = 0; k < 4; k++) sample_q.push_back(jitter(tgt[k], 4));
        n += 4 * reps;
      end else begin
        for (int k = 0; k < 4; k++) sample_q.push_back(RAW_W'($urandom()));
        n += 4;
      end
    end
  endtask

  initial begin
    vref_m = 1660;
    cal_lo_m = 1000;
    cal_hi_m = 1350;
    slot_m = 0;
    foreach (filt_m[i]) filt_m[i] = 0;
    ratio_m = 0;
    cpu_m = '0;
    ext_m = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: zero ratio at start, extremes, zero reference sample, steady levels
    foreach (sample_q[i]) ;
    sample_q.push_back(12'd4095); sample_q.push_back(12'd4095);
    sample_q.push_back(12'd4095); sample_q.push_back(12'd4095);
    sample_q.push_back(12'd0);    sample_q.push_back(12'd0);
    sample_q.push_back(12'd0);    sample_q.push_back(12'd0);
    sample_q.push_back(12'd1);    sample_q.push_back(12'd4095);
    sample_q.push_back(12'd4095); sample_q.push_back(12'd4095);
    sample_q.push_back(12'd1660); sample_q.push_back(12'd0);
    sample_q.push_back(12'd0);    sample_q.push_back(12'd1);
    sample_q.push_back(12'd4095); sample_q.push_back(12'd2048);
    sample_q.push_back(12'd1024); sample_q.push_back(12'd2730);
    wait_idle();

    // default calibration
    fill_random(300);
    wait_idle();
    // full-scale extremes
    write_reg(REG_VREF_CAL, 12'd4095);
    write_reg(REG_TEMP_CAL_LOW, 12'd0);
    write_reg(REG_TEMP_CAL_HIGH, 12'd4095);
    fill_random(300);
    wait_idle();
    // inverted calibration points and zero reference
    write_reg(REG_VREF_CAL, 12'd0);
    write_reg(REG_TEMP_CAL_LOW, 12'd4095);
    write_reg(REG_TEMP_CAL_HIGH, 12'd0);
    fill_random(300);
    wait_idle();
    // equal calibration points hold the cpu temperature
    write_reg(REG_VREF_CAL, 12'd1660);
    write_reg(REG_TEMP_CAL_LOW, 12'd1234);
    write_reg(REG_TEMP_CAL_HIGH, 12'd1234);
    fill_random(300);
    wait_idle();
    // random calibration
    write_reg(REG_VREF_CAL, RAW_W'($urandom()));
    write_reg(REG_TEMP_CAL_LOW, RAW_W'($urandom()));
    write_reg(REG_TEMP_CAL_HIGH, RAW_W'($urandom()));
    fill_random(300);
    wait_idle();
    // back to defaults with no idling
    write_reg(REG_VREF_CAL, 12'd1660);
    write_reg(REG_TEMP_CAL_LOW, 12'd1000);
    write_reg(REG_TEMP_CAL_HIGH, 12'd1350);
    idle_en = 1'b0;
    fill_random(430);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
